// ===== rtl/shell_command_line_normalizer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the command-line normalizer
// Same-cycle and next-cycle implication checks, reset aware.
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_LINE_NORMALIZER_CORE_ASSERT_SVH
`define SHELL_COMMAND_LINE_NORMALIZER_CORE_ASSERT_SVH

// check cons in the same cycle as ante
`define SCLN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("normalizer check failed");

// check cons in the cycle after ante
`define SCLN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("normalizer check failed");

`endif

// ===== rtl/scln_pkg.sv =====
// ----------------------------------------------------------------------------
// scln_pkg
// Character classes, result types and the per-byte decision function.
// ----------------------------------------------------------------------------
`default_nettype none

package scln_pkg;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_string;
      logic       changed;
   } rsp_entry_type;

   // compacted results of one request: entry0 first, entry1 second
   typedef struct packed {
      logic [1:0]    push_cnt;
      rsp_entry_type entry0;
      rsp_entry_type entry1;
   } push_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] res_byte;
      logic       started;
   } byte_dec_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic is_removed(input logic [7:0] c);
      return (c == CHAR_BSLASH) || (c == CHAR_DQUOTE) ||
             (c == CHAR_SQUOTE) || (c == CHAR_CARET);
   endfunction

   function automatic logic is_space_like(input logic [7:0] c);
      return is_ws(c) || (c == CHAR_COMMA) || (c == CHAR_SEMI);
   endfunction

   function automatic logic is_terminator(input logic [7:0] c);
      return is_space_like(c) || (c == CHAR_LPAREN) || (c == CHAR_SLASH);
   endfunction

   // decide one byte given its successor (when has_next)
   function automatic byte_dec_type decide_byte(input logic [7:0] c,
                                                input logic       has_next,
                                                input logic [7:0] nxt,
                                                input logic       started);
      byte_dec_type d;
      logic         trig;
      trig = is_removed(c) || is_upper(c) ||
             (has_next && ((c == CHAR_COMMA) || (c == CHAR_SEMI))) ||
             (has_next && is_ws(c) && is_terminator(nxt));
      d.started = started || trig;
      if (!started && !trig) begin
         d.emit     = 1'b1;
         d.res_byte = c;
      end else if (is_removed(c)) begin
         d.emit     = 1'b0;
         d.res_byte = 8'h00;
      end else if (is_space_like(c)) begin
         d.emit     = !(has_next && is_terminator(nxt));
         d.res_byte = d.emit ? CHAR_SPACE : 8'h00;
      end else begin
         d.emit     = 1'b1;
         d.res_byte = is_upper(c) ? (c + CASE_OFFSET) : c;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/scln_decide.sv =====
// ----------------------------------------------------------------------------
// scln_decide
// Decides the held byte against the incoming one, and the incoming byte
// itself when it ends the string; packs the results for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module scln_decide (
   input  wire logic [7:0]        held_byte,
   input  wire logic              held_valid,
   input  wire logic              started,
   input  wire logic [7:0]        in_byte,
   input  wire logic              is_last,
   output scln_pkg::push_type     push,
   output logic                   started_next
);

   scln_pkg::byte_dec_type  dec_held;
   scln_pkg::byte_dec_type  dec_last;
   scln_pkg::rsp_entry_type res_held;
   scln_pkg::rsp_entry_type res_last;
   logic                    held_emit;
   logic                    started_mid;

   always_comb begin
      dec_held    = scln_pkg::decide_byte(held_byte, 1'b1, in_byte, started);
      started_mid = held_valid ? dec_held.started : started;
      dec_last    = scln_pkg::decide_byte(in_byte, 1'b0, 8'h00, started_mid);
      held_emit   = held_valid && dec_held.emit;

      res_held.out_byte      = dec_held.res_byte;
      res_held.byte_valid    = 1'b1;
      res_held.end_of_string = 1'b0;
      res_held.changed       = 1'b0;

      // a dropped last byte leaves a bare end marker
      res_last.out_byte      = dec_last.emit ? dec_last.res_byte : 8'h00;
      res_last.byte_valid    = dec_last.emit;
      res_last.end_of_string = 1'b1;
      res_last.changed       = dec_last.started;

      push.push_cnt = {1'b0, held_emit} + {1'b0, is_last};
      push.entry0   = held_emit ? res_held : res_last;
      push.entry1   = res_last;
      started_next  = started_mid;
   end

endmodule

`default_nettype wire

// ===== rtl/scln_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// scln_rsp_fifo
// Small result queue: takes up to two entries a cycle, delivers one while the consumer is ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shell_command_line_normalizer_core_assert.svh"

module scln_rsp_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire scln_pkg::push_type        push,
   output logic                           room_for_two,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output scln_pkg::rsp_entry_type        rsp_entry
);

   localparam int unsigned DEPTH = scln_pkg::FIFO_DEPTH;

   scln_pkg::rsp_entry_type          mem_ff [DEPTH];
   logic [scln_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [scln_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [scln_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [scln_pkg::PTR_W-1:0]       wr_ptr_nxt;
   logic                             pop;

   always_comb begin
      pop          = rsp_valid && rsp_ready;
      wr_ptr_nxt   = wr_ptr_ff + 1'b1;
      wr_ptr_in    = wr_ptr_ff + scln_pkg::PTR_W'(push.push_cnt);
      rd_ptr_in    = pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in     = count_ff + scln_pkg::CNT_W'(push.push_cnt)
                     - scln_pkg::CNT_W'(pop);
      rsp_valid    = (count_ff != '0);
      rsp_entry    = mem_ff[rd_ptr_ff];
      room_for_two = (count_ff <= scln_pkg::CNT_W'(DEPTH - 2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.entry0;
      end
      if (push.push_cnt == 2'd2) begin
         mem_ff[wr_ptr_nxt] <= push.entry1;
      end
   end

   `SCLN_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH)
   `SCLN_ASSERT_NOW(a_push_fits, clock, reset, push.push_cnt != 2'd0,
                    (count_ff + push.push_cnt) <= DEPTH)
   `SCLN_ASSERT_NOW(a_push_cnt_legal, clock, reset, 1'b1, push.push_cnt != 2'd3)
   `SCLN_ASSERT_NEXT(a_drain, clock, reset, pop && (push.push_cnt == 2'd0),
                     count_ff == ($past(count_ff) - 1'b1))

endmodule

`default_nettype wire

// ===== rtl/shell_command_line_normalizer_core.sv =====
// Timing: a byte's result is queued at the edge that accepts its successor (or at
//   its own acceptance when it ends the string) and is offered once earlier results drain.
// Throughput: one request per cycle; a last byte may queue two results, and
//   ready drops while the four-entry result queue has fewer than two free slots.
// Reset: synchronous, clears the held byte, trigger flag and result queue.
// ----------------------------------------------------------------------------
// shell_command_line_normalizer_core
// Streams a command line one byte per request, holds one byte back for
// lookahead, normalizes after the first trigger and flags the final result.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_command_line_normalizer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_is_last,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_end_of_string,
   output logic            rsp_changed
);

   // lookahead state: one byte waits for its successor
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic       started_ff, started_in;

   logic                     accept;
   logic                     room_for_two;
   logic                     started_next;
   scln_pkg::push_type       dec_push;
   scln_pkg::push_type       push;
   scln_pkg::rsp_entry_type  rsp_entry;

   // decide the held byte and, on a last byte, the byte itself
   scln_decide u_decide (
      .held_byte    (held_byte_ff),
      .held_valid   (held_valid_ff),
      .started      (started_ff),
      .in_byte      (req_in_byte),
      .is_last      (req_is_last),
      .push         (dec_push),
      .started_next (started_next)
   );

   always_comb begin
      // take a request only when the queue can absorb two results
      req_ready = room_for_two;
      accept    = req_valid && req_ready;

      push          = dec_push;
      push.push_cnt = accept ? dec_push.push_cnt : 2'd0;

      // hold the new byte, or drop everything at the end of the string
      if (accept) begin
         held_byte_in  = req_is_last ? 8'h00 : req_in_byte;
         held_valid_in = !req_is_last;
         started_in    = req_is_last ? 1'b0 : started_next;
      end else begin
         held_byte_in  = held_byte_ff;
         held_valid_in = held_valid_ff;
         started_in    = started_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= 8'h00;
         held_valid_ff <= 1'b0;
         started_ff    <= 1'b0;
      end else begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         started_ff    <= started_in;
      end
   end

   // results wait here so requests keep flowing while the consumer stalls
   scln_rsp_fifo u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_entry    (rsp_entry)
   );

   assign rsp_out_byte      = rsp_entry.out_byte;
   assign rsp_byte_valid    = rsp_entry.byte_valid;
   assign rsp_end_of_string = rsp_entry.end_of_string;
   assign rsp_changed       = rsp_entry.changed;

endmodule

`default_nettype wire
